>>> rtl/core/wpsm_pkg.sv
// wpsm_pkg: shared widths, codes and types of the word pattern stream matcher
// no dependencies; used by the interfaces and by every rtl/core module

package wpsm_pkg;

    localparam int MAX_PATTERN_DEF = 16;

    localparam int WORD_W = 32;
    localparam int IDX_W  = 4;
    localparam int LEN_W  = 5;
    localparam int LINE_W = 32;
    localparam int POS_W  = 16;

    // item opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEXT = 1'b1;

    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1);

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [LINE_W-1:0] t_line;
    typedef logic [POS_W-1:0]  t_pos;

    typedef struct packed {
        logic  op;
        t_idx  pattern_index;
        t_word word_value;
        logic  line_start;
    } t_item;

    // line / word-in-line counters after the current text word
    typedef struct packed {
        t_line line;
        t_pos  pos;
    } t_track;

endpackage

>>> rtl/core/wpsm_if.sv
// wpsm_item_if and wpsm_match_if: valid/ready channels of the matcher
// depends on wpsm_pkg for field widths

interface wpsm_item_if;
    import wpsm_pkg::*;

    logic  valid;
    logic  ready;
    logic  op;
    t_idx  pattern_index;
    t_word word_value;
    logic  line_start;

    modport source (output valid, output op, output pattern_index, output word_value,
                    output line_start, input ready);
    modport sink   (input valid, input op, input pattern_index, input word_value,
                    input line_start, output ready);
endinterface

interface wpsm_match_if;
    import wpsm_pkg::*;

    logic  valid;
    logic  ready;
    t_line match_line;
    t_pos  match_word;

    modport source (output valid, output match_line, output match_word, input ready);
    modport sink   (input valid, input match_line, input match_word, output ready);
endinterface

>>> rtl/core/wpsm_pattern_store.sv
// wpsm_pattern_store: register file of pattern words, all entries visible at once
// depends on wpsm_pkg

module wpsm_pattern_store #(
    parameter int MAX_PATTERN = wpsm_pkg::MAX_PATTERN_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  wpsm_pkg::t_idx                         i_idx,
    input  wpsm_pkg::t_word                        i_word,
    output logic [MAX_PATTERN-1:0][wpsm_pkg::WORD_W-1:0] o_pat
);
    import wpsm_pkg::*;

    localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [MAX_PATTERN-1:0][WORD_W-1:0] r_pat;
    logic                               in_range;

    // loads beyond the store are dropped
    assign in_range = 8'(i_idx) < 8'(MAX_PATTERN);

    always_ff @(posedge i_clk) begin
        if (i_we && in_range) begin
            r_pat[IW'(i_idx)] <= i_word;
        end
    end

    assign o_pat = r_pat;

endmodule

>>> rtl/core/wpsm_line_track.sv
// wpsm_line_track: sliding text window plus line and word-in-line counters
// depends on wpsm_pkg

module wpsm_line_track #(
    parameter int MAX_PATTERN = wpsm_pkg::MAX_PATTERN_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_adv,
    input  wpsm_pkg::t_word                        i_word,
    input  logic                                   i_line_start,
    output logic [MAX_PATTERN-1:0][wpsm_pkg::WORD_W-1:0] o_win_view,
    output wpsm_pkg::t_track                       o_next
);
    import wpsm_pkg::*;

    logic [MAX_PATTERN-1:0][WORD_W-1:0] r_win;
    t_line                              r_line;
    t_pos                               r_pos;
    logic                               new_line;
    t_pos                               pos_base;

    // window as it stands once the current word is shifted in
    always_comb begin
        o_win_view[0] = i_word;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            o_win_view[k] = r_win[k-1];
        end
    end

    // text before any line opens line one
    assign new_line = i_line_start || (r_line == '0);
    assign pos_base = new_line ? '0 : r_pos;

    always_comb begin
        o_next.line = r_line;
        if (new_line && (r_line != '1)) begin
            o_next.line = r_line + LINE_W'(1);
        end
        o_next.pos = (pos_base == '1) ? pos_base : pos_base + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win  <= '0;
            r_line <= '0;
            r_pos  <= '0;
        end else if (i_adv) begin
            r_win  <= o_win_view;
            r_line <= o_next.line;
            r_pos  <= o_next.pos;
        end
    end

endmodule

>>> rtl/core/wpsm_window_cmp.sv
// wpsm_window_cmp: parallel compare of the newest window words with the pattern
// depends on wpsm_pkg

module wpsm_window_cmp #(
    parameter int MAX_PATTERN = wpsm_pkg::MAX_PATTERN_DEF
) (
    input  logic [MAX_PATTERN-1:0][wpsm_pkg::WORD_W-1:0] i_win,
    input  logic [MAX_PATTERN-1:0][wpsm_pkg::WORD_W-1:0] i_pat,
    input  wpsm_pkg::t_len                         i_len_raw,
    input  wpsm_pkg::t_pos                         i_pos,
    output logic                                   o_hit,
    output wpsm_pkg::t_pos                         o_match_word
);
    import wpsm_pkg::*;

    localparam int CNT_W = $clog2(MAX_PATTERN + 1);
    localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LW    = (CNT_W > LEN_W) ? CNT_W : LEN_W;

    logic [LW-1:0]          len_ext;
    logic [LW-1:0]          len_clamp;
    logic [CNT_W-1:0]       len;
    logic [MAX_PATTERN-1:0] lane_ok;

    // zero counts as one, anything past the window as the full window
    always_comb begin
        len_ext   = LW'(i_len_raw);
        len_clamp = len_ext;
        if (len_ext == '0) begin
            len_clamp = LW'(1);
        end else if (len_ext > LW'(MAX_PATTERN)) begin
            len_clamp = LW'(MAX_PATTERN);
        end
        len = CNT_W'(len_clamp);
    end

    // window word j lines up with pattern word len-1-j
    always_comb begin
        logic [CNT_W:0] pidx;
        for (int j = 0; j < MAX_PATTERN; j++) begin
            pidx       = (CNT_W+1)'(len) - (CNT_W+1)'(j) - (CNT_W+1)'(1);
            lane_ok[j] = ((CNT_W+1)'(j) >= (CNT_W+1)'(len))
                         || (i_win[j] == i_pat[pidx[IW-1:0]]);
        end
    end

    assign o_hit        = (&lane_ok) && (i_pos >= POS_W'(len));
    assign o_match_word = (i_pos == '1) ? i_pos : i_pos - POS_W'(len) + POS_W'(1);

endmodule

>>> rtl/core/word_pattern_stream_matcher.sv
// word_pattern_stream_matcher: top level of the word pattern stream matcher
// depends on wpsm_pkg, wpsm_if, wpsm_pattern_store, wpsm_line_track, wpsm_window_cmp

// Finds every occurrence, overlaps included, of a pattern of up to MAX_PATTERN
// 32-bit words in a stream of 32-bit text words. A load transfer (op 0) writes
// one pattern word; a text transfer (op 1) shifts a word into the window and
// advances the line and word-in-line counters, and yields one result when the
// newest pattern_length words equal the pattern and all lie in the current
// line. The result carries the line number and the position of the match's
// first word, both counted from 1 and saturating. Every pattern entry in use
// must be loaded before text is compared against it. pattern_length is written
// through i_cfg_we/i_cfg_wdata while the block is idle; 0 acts as 1, values
// above MAX_PATTERN act as MAX_PATTERN. Throughput is one item per cycle with
// no stall of its own; a result passes from the input register, where the item
// waits while the window compare, the single stage of work, works on it and sets
// the rate, into the output register. Back-pressure on the result channel holds
// the result and, one item later, the input channel.

module word_pattern_stream_matcher #(
    parameter int MAX_PATTERN = wpsm_pkg::MAX_PATTERN_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  wpsm_pkg::t_len       i_cfg_wdata,
    wpsm_item_if.sink            i_item,
    wpsm_match_if.source         o_match
);
    import wpsm_pkg::*;

    // config register
    t_len r_cfg_len;

    // input register
    logic  r_in_valid;
    t_item r_in;

    // result register
    logic  r_out_valid;
    t_line r_out_line;
    t_pos  r_out_word;

    // stage control
    logic out_free;
    logic fire;
    logic text_adv;
    logic load_we;

    logic [MAX_PATTERN-1:0][WORD_W-1:0] pat;
    logic [MAX_PATTERN-1:0][WORD_W-1:0] win_view;
    t_track                             next_cnt;
    logic                               hit;
    t_pos                               match_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_len <= LEN_RESET;
        end else if (i_cfg_we) begin
            r_cfg_len <= i_cfg_wdata;
        end
    end

    // the result register is free when empty or being drained this cycle
    assign out_free = !r_out_valid || o_match.ready;
    assign fire     = r_in_valid && out_free;
    assign text_adv = fire && (r_in.op == OP_TEXT);
    assign load_we  = fire && (r_in.op == OP_LOAD);

    // input register refills in the same cycle it hands its item on
    assign i_item.ready = !r_in_valid || fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.ready) begin
            r_in_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in.op            <= i_item.op;
            r_in.pattern_index <= i_item.pattern_index;
            r_in.word_value    <= i_item.word_value;
            r_in.line_start    <= i_item.line_start;
        end
    end

    wpsm_pattern_store #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (load_we),
        .i_idx  (r_in.pattern_index),
        .i_word (r_in.word_value),
        .o_pat  (pat)
    );

    wpsm_line_track #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_track (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (text_adv),
        .i_word       (r_in.word_value),
        .i_line_start (r_in.line_start),
        .o_win_view   (win_view),
        .o_next       (next_cnt)
    );

    wpsm_window_cmp #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_cmp (
        .i_win        (win_view),
        .i_pat        (pat),
        .i_len_raw    (r_cfg_len),
        .i_pos        (next_cnt.pos),
        .o_hit        (hit),
        .o_match_word (match_word)
    );

    // result register: loads only on a text word that completes a match
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= text_adv && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (text_adv && hit) begin
            r_out_line <= next_cnt.line;
            r_out_word <= match_word;
        end
    end

    assign o_match.valid      = r_out_valid;
    assign o_match.match_line = r_out_line;
    assign o_match.match_word = r_out_word;

    // a reported match always sits inside a counted line
    a_match_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_line != '0) && (r_out_word != '0))
        else $error("match reported outside any counted line");

    // a load item never raises a result
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_we |=> !r_out_valid)
        else $error("load item produced a result");

    // a freshly loaded result comes from a text word
    a_result_from_text: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && $past(out_free)) |-> $past(text_adv))
        else $error("result loaded without a text transfer");

endmodule
